// ===== sv/tba_pkg.sv =====
package tba_pkg;

    // Fixed-point constants
    localparam int unsigned FracLog = 30;
    localparam logic [27:0] Ln2Q28 = 28'd186065280;
    // round(2^40 * 20 / 5963)
    localparam logic [31:0] InvT25Q40 = 32'(((64'd1 << 40) * 64'd20 + 64'd2981) / 64'd5963);
    localparam logic [47:0] CentiScaleQ40 = 48'd100 << 40;
    localparam logic [15:0] ZeroCCentiK = 16'd27315;
    localparam logic [15:0] TempMax = 16'd32767;

    // Status codes
    localparam logic [1:0] StOk = 2'd0;
    localparam logic [1:0] StHigh = 2'd1;
    localparam logic [1:0] StZero = 2'd2;

    // Register indexes
    localparam logic [1:0] RegBeta = 2'd0;
    localparam logic [1:0] RegFull = 2'd1;
    localparam logic [1:0] RegSamples = 2'd2;

    // Datapath commands
    typedef struct packed {
        logic accum;      // add sample, bump count
        logic start_la;   // load log2 unit with a
        logic start_lb;   // load log2 unit with sum
        logic log_step;   // one squaring step
        logic ln_mul;     // |ln q| multiply
        logic div_start;  // start divide by beta
        logic div_step;
        logic rec_start;  // start reciprocal divide
        logic rec_step;
        logic finish;     // form result
    } t_cmd;

    typedef struct packed {
        logic block_done; // count reached N after this sample
        logic special;    // sum zero or at/above full scale
        logic neg_sat;    // reciprocal would go non-positive
    } t_stat;

endpackage

// ===== sv/tba_datapath.sv =====
module tba_datapath #(
    parameter int MaxSamples = 1024,
    parameter int SumW = 26
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_wr_en,
    input  logic [1:0]        i_cfg_index,
    input  logic [15:0]       i_cfg_data,
    input  logic [15:0]       i_sample_mv,
    input  tba_pkg::t_cmd     i_cmd,
    output tba_pkg::t_stat    o_stat,
    output logic signed [15:0] o_temp,
    output logic [1:0]        o_status
);
    import tba_pkg::*;

    localparam int NW = $clog2(MaxSamples + 1);
    localparam int AW = SumW + 1;            // full*N width headroom
    localparam int EW = $clog2(AW + 1);
    localparam int LW = EW + FracLog;        // log2 value width
    localparam int QW = LW + 10;             // Q.40 magnitude width
    localparam int RW = 48;                  // reciprocal quotient width

    logic [15:0] r_beta, r_full;
    logic [10:0] r_nreg;
    logic [SumW-1:0] r_sum;
    logic [10:0] r_cnt;

    // Effective block size
    logic [NW-1:0] w_n;
    always_comb begin
        if (r_nreg == 11'd0) w_n = NW'(1);
        else if (32'(r_nreg) > 32'(MaxSamples)) w_n = NW'(MaxSamples);
        else w_n = NW'(r_nreg);
    end

    // Config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_beta <= 16'd3950;
            r_full <= 16'd5000;
            r_nreg <= 11'd16;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                RegBeta: r_beta <= i_cfg_data;
                RegFull: r_full <= i_cfg_data;
                RegSamples: r_nreg <= i_cfg_data[10:0];
                default: ;
            endcase
        end
    end

    // Accumulator
    logic [SumW-1:0] n_sum;
    logic [10:0] n_cnt;
    assign n_sum = r_sum + SumW'(i_sample_mv);
    assign n_cnt = r_cnt + 11'd1;
    assign o_stat.block_done = (32'(n_cnt) >= 32'(w_n));

    logic [SumW-1:0] r_bsum;   // captured block sum
    logic [AW-1:0]   r_a;
    logic            r_spec;
    logic [1:0]      r_spec_st;
    logic [AW-1:0]   w_fulln;
    assign w_fulln = AW'(r_full * w_n);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= '0;
            r_cnt <= '0;
        end else if (i_cmd.accum) begin
            if (o_stat.block_done) begin
                r_sum <= '0;
                r_cnt <= '0;
            end else begin
                r_sum <= n_sum;
                r_cnt <= n_cnt;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accum && o_stat.block_done) begin
            r_bsum <= n_sum;
            r_spec <= (n_sum == '0) || (AW'(n_sum) >= w_fulln);
            r_spec_st <= (n_sum == '0) ? StZero : StHigh;
            r_a <= w_fulln - AW'(n_sum);
        end
    end
    assign o_stat.special = r_spec;

    // log2 unit: leading-one then squaring, one step per cycle
    logic [FracLog+1:0] r_m;
    logic [FracLog-1:0] r_frac;
    logic [EW-1:0]      r_e;
    logic [LW-1:0]      r_la;
    logic [AW-1:0]      w_lsrc;
    logic [EW-1:0]      w_e;
    logic [2*FracLog+3:0] w_sq;
    logic [FracLog+1:0] w_m2;

    assign w_lsrc = i_cmd.start_la ? r_a : AW'(r_bsum);
    always_comb begin
        w_e = '0;
        for (int i = 1; i < AW; i++) begin
            if (w_lsrc[i]) w_e = EW'(i);
        end
    end
    assign w_sq = (2*FracLog+4)'(r_m) * (2*FracLog+4)'(r_m);
    assign w_m2 = (FracLog+2)'(w_sq >> FracLog);

    always_ff @(posedge i_clk) begin
        if (i_cmd.start_la || i_cmd.start_lb) begin
            if (i_cmd.start_lb) r_la <= {r_e, r_frac};
            r_e <= w_e;
            r_frac <= '0;
            r_m <= (FracLog+2)'(((AW+FracLog)'(w_lsrc) << FracLog) >> w_e);
        end else if (i_cmd.log_step) begin
            if (w_m2[FracLog+1]) begin
                r_m <= w_m2 >> 1;
                r_frac <= {r_frac[FracLog-2:0], 1'b1};
            end else begin
                r_m <= w_m2;
                r_frac <= {r_frac[FracLog-2:0], 1'b0};
            end
        end
    end

    // |ln q| = |la - lb| * ln2
    logic [LW-1:0] w_lb, w_mag;
    logic          r_neg;
    logic [QW-1:0] r_lnmag;   // Q.30 magnitude << 10 = Q.40 numerator
    assign w_lb = {r_e, r_frac};
    assign w_mag = (r_la < w_lb) ? (w_lb - r_la) : (r_la - w_lb);

    always_ff @(posedge i_clk) begin
        if (i_cmd.ln_mul) begin
            r_neg <= r_la < w_lb;
            r_lnmag <= QW'(((LW+28)'(w_mag) * (LW+28)'(Ln2Q28)) >> 28) << 10;
        end
    end

    // Shared restoring divider, one quotient bit per cycle
    localparam int DW = 48;
    logic [DW-1:0] r_q, r_rem, r_den;
    logic [DW:0]   w_trial;
    assign w_trial = {r_rem, r_q[DW-1]} - {1'b0, r_den};

    logic [15:0] w_beta;
    assign w_beta = (r_beta == 16'd0) ? 16'd1 : r_beta;

    logic [DW-1:0] w_inv;
    assign w_inv = r_neg ? (DW'(InvT25Q40) - r_q) : (DW'(InvT25Q40) + r_q);
    assign o_stat.neg_sat = r_neg && (r_q >= DW'(InvT25Q40));

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_start) begin
            r_q <= DW'(r_lnmag);
            r_rem <= '0;
            r_den <= DW'(w_beta);
        end else if (i_cmd.rec_start) begin
            r_q <= CentiScaleQ40 + (w_inv >> 1);
            r_rem <= '0;
            r_den <= w_inv;
        end else if (i_cmd.div_step || i_cmd.rec_step) begin
            if (!w_trial[DW]) begin
                r_rem <= w_trial[DW-1:0];
                r_q <= {r_q[DW-2:0], 1'b1};
            end else begin
                r_rem <= {r_rem[DW-2:0], r_q[DW-1]};
                r_q <= {r_q[DW-2:0], 1'b0};
            end
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            if (r_spec) begin
                o_temp <= '0;
                o_status <= r_spec_st;
            end else if (o_stat.neg_sat) begin
                o_temp <= signed'(TempMax);
                o_status <= StOk;
            end else begin
                o_status <= StOk;
                if (r_q >= RW'(32'(TempMax) + 32'(ZeroCCentiK))) o_temp <= signed'(TempMax);
                else o_temp <= signed'(16'(r_q[16:0] - 17'(ZeroCCentiK)));
            end
        end
    end

endmodule

// ===== sv/tba_ctrl.sv =====
module tba_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_stall,
    output logic           o_valid,
    input  logic           i_stall,
    input  tba_pkg::t_stat i_stat,
    output tba_pkg::t_cmd  o_cmd
);
    import tba_pkg::*;

    localparam logic [3:0] SIdle = 4'd0;
    localparam logic [3:0] SChk  = 4'd1;
    localparam logic [3:0] SLa   = 4'd2;
    localparam logic [3:0] SLaSt = 4'd3;
    localparam logic [3:0] SLb   = 4'd4;
    localparam logic [3:0] SLbSt = 4'd5;
    localparam logic [3:0] SMul  = 4'd6;
    localparam logic [3:0] SDivS = 4'd7;
    localparam logic [3:0] SDiv  = 4'd8;
    localparam logic [3:0] SRecS = 4'd9;
    localparam logic [3:0] SRec  = 4'd10;
    localparam logic [3:0] SFin  = 4'd11;
    localparam logic [3:0] SOut  = 4'd12;

    logic [3:0] r_state, n_state;
    logic [5:0] r_cnt, n_cnt;
    logic       w_acc;

    assign o_stall = (r_state != SIdle);
    assign o_valid = (r_state == SOut);
    assign w_acc = i_valid && !o_stall;

    always_comb begin
        n_state = r_state;
        n_cnt = r_cnt;
        o_cmd = '0;
        case (r_state)
            SIdle: begin
                o_cmd.accum = w_acc;
                if (w_acc && i_stat.block_done) n_state = SChk;
            end
            SChk: n_state = i_stat.special ? SFin : SLa;
            SLa: begin
                o_cmd.start_la = 1'b1;
                n_cnt = 6'd0;
                n_state = SLaSt;
            end
            SLaSt: begin
                o_cmd.log_step = 1'b1;
                n_cnt = r_cnt + 6'd1;
                if (r_cnt == 6'(FracLog - 1)) n_state = SLb;
            end
            SLb: begin
                o_cmd.start_lb = 1'b1;
                n_cnt = 6'd0;
                n_state = SLbSt;
            end
            SLbSt: begin
                o_cmd.log_step = 1'b1;
                n_cnt = r_cnt + 6'd1;
                if (r_cnt == 6'(FracLog - 1)) n_state = SMul;
            end
            SMul: begin
                o_cmd.ln_mul = 1'b1;
                n_state = SDivS;
            end
            SDivS: begin
                o_cmd.div_start = 1'b1;
                n_cnt = 6'd0;
                n_state = SDiv;
            end
            SDiv: begin
                o_cmd.div_step = 1'b1;
                n_cnt = r_cnt + 6'd1;
                if (r_cnt == 6'd47) n_state = SRecS;
            end
            SRecS: begin
                if (i_stat.neg_sat) n_state = SFin;
                else begin
                    o_cmd.rec_start = 1'b1;
                    n_cnt = 6'd0;
                    n_state = SRec;
                end
            end
            SRec: begin
                o_cmd.rec_step = 1'b1;
                n_cnt = r_cnt + 6'd1;
                if (r_cnt == 6'd47) n_state = SFin;
            end
            SFin: begin
                o_cmd.finish = 1'b1;
                n_state = SOut;
            end
            SOut: if (!i_stall) n_state = SIdle;
            default: n_state = SIdle;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= SIdle;
            r_cnt <= '0;
        end else begin
            r_state <= n_state;
            r_cnt <= n_cnt;
        end
    end

`ifndef SYNTHESIS
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != SIdle) |-> !o_cmd.accum) else $error("accum while busy");
    a_out_after_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(r_state) == SFin) else $error("result without finish");
    a_hold_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> o_valid) else $error("result dropped");
`endif

endmodule

// ===== sv/thermistor_beta_averager_core.sv =====
// Thermistor beta averager: sums millivolt samples and, once samples_per_result
// have arrived, emits one temperature in 0.01 degC (or an error status). A
// sample that does not close a block is accumulated without a stall. The
// closing sample starts a sequence that computes the result: two 30-step log2
// passes on a shared squaring unit, one multiply, then two passes of a shared
// bit-serial divider (divide by beta, then reciprocal). An error status skips
// the log and divide passes, and a reciprocal that would go non-positive skips
// the second divide. No sample is taken until the result leaves.
module thermistor_beta_averager_core #(
    parameter int MaxSamples = 1024
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_wr_en,
    input  logic [1:0]        i_cfg_index,
    input  logic [15:0]       i_cfg_data,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [15:0]       i_sample_mv,
    output logic              o_valid,
    input  logic              i_stall,
    output logic signed [15:0] o_temperature_centi_c,
    output logic [1:0]        o_status
);
    import tba_pkg::*;

    localparam int SumW = 16 + $clog2(MaxSamples + 1);

    t_cmd  w_cmd;
    t_stat w_stat;

    tba_ctrl u_ctrl (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .o_valid, .i_stall,
        .i_stat(w_stat), .o_cmd(w_cmd)
    );

    tba_datapath #(.MaxSamples(MaxSamples), .SumW(SumW)) u_dp (
        .i_clk, .i_rst_n, .i_cfg_wr_en, .i_cfg_index, .i_cfg_data, .i_sample_mv,
        .i_cmd(w_cmd), .o_stat(w_stat),
        .o_temp(o_temperature_centi_c), .o_status
    );

endmodule
